// File: design/sfpalu_pkg.sv
`timescale 1ns / 1ps

package sfpalu_pkg;

  typedef enum logic [4:0] {
    OP_ADD       = 5'd0,
    OP_SUB       = 5'd1,
    OP_MULT      = 5'd2,
    OP_MULT0     = 5'd3,
    OP_MAC       = 5'd4,
    OP_MAC0      = 5'd5,
    OP_MSU0      = 5'd6,
    OP_MAC_R     = 5'd7,
    OP_ROUND     = 5'd8,
    OP_LSHL      = 5'd9,
    OP_LSHR      = 5'd10,
    OP_SHL       = 5'd11,
    OP_SHR       = 5'd12,
    OP_NORM_S    = 5'd13,
    OP_NORM_L    = 5'd14,
    OP_EXTRACT_L = 5'd15,
    OP_EXTRACT_H = 5'd16,
    OP_LMAX      = 5'd17,
    OP_LMIN      = 5'd18,
    OP_SMIN      = 5'd19,
    OP_SAND      = 5'd20
  } op_t;

  localparam logic signed [31:0] MAX32   = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32   = 32'sh8000_0000;
  localparam logic signed [31:0] MULT_OV = 32'sh4000_0000;
  localparam logic signed [32:0] RND     = 33'sh0_0000_8000;
  localparam logic signed [15:0] MAX16   = 16'sh7fff;
  localparam logic signed [15:0] MIN16   = 16'sh8000;

  // One input word as it travels down the pipeline.
  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] long_a;
    logic signed [31:0] long_b;
    logic signed [15:0] short_a;
    logic signed [15:0] short_b;
  } in_t;

  // True when a 33-bit sum does not fit in 32 bits.
  function automatic logic ovf33(input logic signed [32:0] x);
    return x[32] != x[31];
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] v;
    if (x[32] != x[31]) begin
      v = x[32] ? MIN32 : MAX32;
    end else begin
      v = x[31:0];
    end
    return v;
  endfunction

  function automatic logic signed [32:0] ext33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  // Redundant sign bits of a 32-bit word; all-sign words give 31.
  function automatic logic [4:0] sign_count32(input logic [31:0] x);
    logic [31:0] y;
    logic [4:0]  cnt;
    y   = x ^ {32{x[31]}};
    cnt = 5'd31;
    for (int i = 0; i < 31; i++) begin
      if (y[i]) begin
        cnt = 5'(30 - i);
      end
    end
    return cnt;
  endfunction

  function automatic logic [3:0] sign_count16(input logic [15:0] x);
    logic [15:0] y;
    logic [3:0]  cnt;
    y   = x ^ {16{x[15]}};
    cnt = 4'd15;
    for (int i = 0; i < 15; i++) begin
      if (y[i]) begin
        cnt = 4'(14 - i);
      end
    end
    return cnt;
  endfunction

endpackage

// File: design/sfpalu_exec.sv
`timescale 1ns / 1ps

// Second half of the ALU: everything after the 16x16 product.
module sfpalu_exec (
  input  sfpalu_pkg::in_t     op,
  input  logic signed [31:0]  prod,
  output logic signed [31:0]  res,
  output logic                ovf
);

  logic signed [31:0] la;
  logic signed [31:0] lb;
  logic signed [15:0] sa;
  logic signed [15:0] sb;

  logic               lmult_ovf;
  logic signed [31:0] lmult;

  logic signed [32:0] add_s;
  logic signed [32:0] sub_s;
  logic signed [32:0] mac_s;
  logic signed [32:0] mac0_s;
  logic signed [32:0] msu_s;
  logic signed [31:0] mac_sat;
  logic signed [32:0] macr_s;
  logic signed [31:0] macr_sat;
  logic signed [32:0] rnd_s;
  logic signed [31:0] rnd_sat;

  logic               neg;
  logic [16:0]        mag;
  logic [5:0]         k32;
  logic [4:0]         k16;

  logic [63:0]        sh64;
  logic               fit32;
  logic signed [31:0] left32;
  logic signed [31:0] right32;
  logic [31:0]        sh32;
  logic               fit16;
  logic signed [15:0] left16;
  logic signed [15:0] right16;

  logic signed [15:0] smin;
  logic [15:0]        sand;

  assign la = op.long_a;
  assign lb = op.long_b;
  assign sa = op.short_a;
  assign sb = op.short_b;

  // Doubling the product only overflows for -32768 * -32768.
  assign lmult_ovf = (prod == sfpalu_pkg::MULT_OV);
  assign lmult     = lmult_ovf ? sfpalu_pkg::MAX32 : {prod[30:0], 1'b0};

  assign add_s    = sfpalu_pkg::ext33(la) + sfpalu_pkg::ext33(lb);
  assign sub_s    = sfpalu_pkg::ext33(la) - sfpalu_pkg::ext33(lb);
  assign mac_s    = sfpalu_pkg::ext33(la) + sfpalu_pkg::ext33(lmult);
  assign mac0_s   = sfpalu_pkg::ext33(la) + sfpalu_pkg::ext33(prod);
  assign msu_s    = sfpalu_pkg::ext33(la) - sfpalu_pkg::ext33(prod);
  assign mac_sat  = sfpalu_pkg::sat33(mac_s);
  assign macr_s   = sfpalu_pkg::ext33(mac_sat) + sfpalu_pkg::RND;
  assign macr_sat = sfpalu_pkg::sat33(macr_s);
  assign rnd_s    = sfpalu_pkg::ext33(la) + sfpalu_pkg::RND;
  assign rnd_sat  = sfpalu_pkg::sat33(rnd_s);

  // Shift count magnitude, clamped to the word width.
  assign neg = sb[15];
  assign mag = neg ? (17'd0 - {sb[15], sb}) : {1'b0, sb};
  assign k32 = (mag > 17'd32) ? 6'd32 : mag[5:0];
  assign k16 = (mag > 17'd16) ? 5'd16 : mag[4:0];

  // A left shift fits when no significant bit reaches past the sign.
  assign sh64    = {{32{la[31]}}, la} << k32;
  assign fit32   = (sh64[63:31] == {33{sh64[63]}});
  assign left32  = fit32 ? sh64[31:0] : (la[31] ? sfpalu_pkg::MIN32 : sfpalu_pkg::MAX32);
  assign right32 = la >>> k32;

  assign sh32    = {{16{sa[15]}}, sa} << k16;
  assign fit16   = (sh32[31:15] == {17{sh32[31]}});
  assign left16  = fit16 ? sh32[15:0] : (sa[15] ? sfpalu_pkg::MIN16 : sfpalu_pkg::MAX16);
  assign right16 = sa >>> k16;

  assign smin = (sa <= sb) ? sa : sb;
  assign sand = sa & sb;

  always_comb begin
    res = '0;
    ovf = 1'b0;
    case (op.func)
      sfpalu_pkg::OP_ADD: begin
        res = sfpalu_pkg::sat33(add_s);
        ovf = sfpalu_pkg::ovf33(add_s);
      end
      sfpalu_pkg::OP_SUB: begin
        res = sfpalu_pkg::sat33(sub_s);
        ovf = sfpalu_pkg::ovf33(sub_s);
      end
      sfpalu_pkg::OP_MULT: begin
        res = lmult;
        ovf = lmult_ovf;
      end
      sfpalu_pkg::OP_MULT0: begin
        res = prod;
      end
      sfpalu_pkg::OP_MAC: begin
        res = mac_sat;
        ovf = lmult_ovf | sfpalu_pkg::ovf33(mac_s);
      end
      sfpalu_pkg::OP_MAC0: begin
        res = sfpalu_pkg::sat33(mac0_s);
        ovf = sfpalu_pkg::ovf33(mac0_s);
      end
      sfpalu_pkg::OP_MSU0: begin
        res = sfpalu_pkg::sat33(msu_s);
        ovf = sfpalu_pkg::ovf33(msu_s);
      end
      sfpalu_pkg::OP_MAC_R: begin
        res = {{16{macr_sat[31]}}, macr_sat[31:16]};
        ovf = lmult_ovf | sfpalu_pkg::ovf33(mac_s) | sfpalu_pkg::ovf33(macr_s);
      end
      sfpalu_pkg::OP_ROUND: begin
        res = {{16{rnd_sat[31]}}, rnd_sat[31:16]};
        ovf = sfpalu_pkg::ovf33(rnd_s);
      end
      sfpalu_pkg::OP_LSHL: begin
        res = neg ? right32 : left32;
        ovf = !neg && !fit32;
      end
      sfpalu_pkg::OP_LSHR: begin
        res = neg ? left32 : right32;
        ovf = neg && !fit32;
      end
      sfpalu_pkg::OP_SHL: begin
        res = neg ? {{16{right16[15]}}, right16} : {{16{left16[15]}}, left16};
        ovf = !neg && !fit16;
      end
      sfpalu_pkg::OP_SHR: begin
        res = neg ? {{16{left16[15]}}, left16} : {{16{right16[15]}}, right16};
        ovf = neg && !fit16;
      end
      sfpalu_pkg::OP_NORM_S: begin
        res = (sa == 16'sd0) ? 32'sd0 : {28'd0, sfpalu_pkg::sign_count16(sa)};
      end
      sfpalu_pkg::OP_NORM_L: begin
        res = (la == 32'sd0) ? 32'sd0 : {27'd0, sfpalu_pkg::sign_count32(la)};
      end
      sfpalu_pkg::OP_EXTRACT_L: begin
        res = {{16{la[15]}}, la[15:0]};
      end
      sfpalu_pkg::OP_EXTRACT_H: begin
        res = {{16{la[31]}}, la[31:16]};
      end
      sfpalu_pkg::OP_LMAX: begin
        res = (la >= lb) ? la : lb;
      end
      sfpalu_pkg::OP_LMIN: begin
        res = (la <= lb) ? la : lb;
      end
      sfpalu_pkg::OP_SMIN: begin
        res = {{16{smin[15]}}, smin};
      end
      sfpalu_pkg::OP_SAND: begin
        res = {{16{sand[15]}}, sand};
      end
      default: begin
        res = '0;
        ovf = 1'b0;
      end
    endcase
  end

endmodule

// File: design/saturating_fixed_point_alu_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// input    in_valid / in_ready      func, long_a, long_b, short_a, short_b
// output   out_valid / out_ready    result, overflow
//
// Three register stages: input register, product register, result register.
// An accepted word passes the input, product and result registers in turn before out_valid
// rises; one word is taken every cycle while out_ready is high.
// The 16x16 multiplier sits alone between the first two stages.
// A stalled output backs up stage by stage; empty stages keep filling.
// rst empties all stages synchronously.
module saturating_fixed_point_alu_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         func,
  input  logic signed [31:0] long_a,
  input  logic signed [31:0] long_b,
  input  logic signed [15:0] short_a,
  input  logic signed [15:0] short_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result,
  output logic               overflow
);

  logic               s1_valid;
  sfpalu_pkg::in_t    s1_op;
  logic               s2_valid;
  sfpalu_pkg::in_t    s2_op;
  logic signed [31:0] s2_prod;
  logic signed [31:0] prod_next;

  logic               out_free;
  logic               s2_free;
  logic               s1_free;

  logic signed [31:0] result_next;
  logic               overflow_next;

  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  assign prod_next = s1_op.short_a * s1_op.short_b;

  sfpalu_exec u_exec (
    .op   (s2_op),
    .prod (s2_prod),
    .res  (result_next),
    .ovf  (overflow_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_op.func    <= func;
      s1_op.long_a  <= long_a;
      s1_op.long_b  <= long_b;
      s1_op.short_a <= short_a;
      s1_op.short_b <= short_b;
    end
    if (s2_free && s1_valid) begin
      s2_op   <= s1_op;
      s2_prod <= prod_next;
    end
    if (out_free && s2_valid) begin
      result   <= result_next;
      overflow <= overflow_next;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          RANDOM_PER_PHASE = 300;
  localparam int          REPORT_LIMIT = 40;
  localparam logic [4:0]  OP_UNUSED_TOP = 5'd31;
  localparam longint      Q31_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint      Q31_MIN = -64'sh0000_0000_8000_0000;
  localparam longint      Q15_MAX = 64'sd32767;
  localparam longint      Q15_MIN = -64'sd32768;

  typedef struct {
    logic [4:0]  func;
    logic [31:0] result;
    logic        overflow;
  } alu_outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [4:0]         func = '0;
  logic signed [31:0] long_a = '0;
  logic signed [31:0] long_b = '0;
  logic signed [15:0] short_a = '0;
  logic signed [15:0] short_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result;
  logic               overflow;

  sfpalu_pkg::in_t pending_words[$];
  alu_outcome_t    predicted_results[$];
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  bit              q_sat;

  saturating_fixed_point_alu_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .long_a    (long_a),
    .long_b    (long_b),
    .short_a   (short_a),
    .short_b   (short_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .overflow  (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturation helpers record any clipping in q_sat.
  function automatic longint clip_q31(input longint x);
    if (x > Q31_MAX) begin
      q_sat = 1'b1;
      return Q31_MAX;
    end
    if (x < Q31_MIN) begin
      q_sat = 1'b1;
      return Q31_MIN;
    end
    return x;
  endfunction

  function automatic longint q31_left(input longint x, input longint n);
    longint v;
    v = x;
    if (n > 32) n = 32;
    for (longint i = 0; i < n; i++) begin
      if (v > 64'sh3fff_ffff) begin
        q_sat = 1'b1;
        return Q31_MAX;
      end
      if (v < -64'sh4000_0000) begin
        q_sat = 1'b1;
        return Q31_MIN;
      end
      v = v * 2;
    end
    return v;
  endfunction

  function automatic longint q31_right(input longint x, input longint n);
    if (n >= 31) return (x < 0) ? -1 : 0;
    return x >>> n;
  endfunction

  function automatic longint q15_left(input longint x, input longint n);
    longint v;
    if (n > 15) begin
      if (x == 0) return 0;
      q_sat = 1'b1;
      return (x > 0) ? Q15_MAX : Q15_MIN;
    end
    v = x * (64'sd1 << n);
    if (v > Q15_MAX || v < Q15_MIN) begin
      q_sat = 1'b1;
      return (x > 0) ? Q15_MAX : Q15_MIN;
    end
    return v;
  endfunction

  function automatic longint q15_right(input longint x, input longint n);
    if (n >= 15) return (x < 0) ? -1 : 0;
    return x >>> n;
  endfunction

  // Count of redundant sign bits; all-ones gives the full width minus one.
  function automatic longint sign_bits(input longint x, input longint lim, input longint full);
    longint c;
    c = 0;
    if (x == 0) return 0;
    if (x == -1) return full;
    if (x < 0) x = ~x;
    while (x < lim) begin
      x = x * 2;
      c++;
    end
    return c;
  endfunction

  function automatic alu_outcome_t alu_predict(input sfpalu_pkg::in_t w);
    alu_outcome_t       o;
    longint             la, lb, sa, sb, prod, r;
    logic signed [15:0] half;
    la    = $signed(w.long_a);
    lb    = $signed(w.long_b);
    sa    = $signed(w.short_a);
    sb    = $signed(w.short_b);
    prod  = sa * sb;
    r     = 0;
    q_sat = 1'b0;
    case (w.func)
      sfpalu_pkg::OP_ADD:   r = clip_q31(la + lb);
      sfpalu_pkg::OP_SUB:   r = clip_q31(la - lb);
      sfpalu_pkg::OP_MULT:  r = clip_q31(2 * prod);
      sfpalu_pkg::OP_MULT0: r = prod;
      sfpalu_pkg::OP_MAC:   r = clip_q31(la + clip_q31(2 * prod));
      sfpalu_pkg::OP_MAC0:  r = clip_q31(la + prod);
      sfpalu_pkg::OP_MSU0:  r = clip_q31(la - prod);
      sfpalu_pkg::OP_MAC_R:
        r = clip_q31(clip_q31(la + clip_q31(2 * prod)) + 64'sh8000) >>> 16;
      sfpalu_pkg::OP_ROUND: r = clip_q31(la + 64'sh8000) >>> 16;
      sfpalu_pkg::OP_LSHL: begin
        if (sb <= 0) r = q31_right(la, (sb < -32) ? 32 : -sb);
        else r = q31_left(la, sb);
      end
      sfpalu_pkg::OP_LSHR: begin
        if (sb < 0) r = q31_left(la, (sb < -32) ? 32 : -sb);
        else r = q31_right(la, sb);
      end
      sfpalu_pkg::OP_SHL: begin
        if (sb < 0) r = q15_right(sa, (sb < -16) ? 16 : -sb);
        else r = q15_left(sa, sb);
      end
      sfpalu_pkg::OP_SHR: begin
        if (sb < 0) r = q15_left(sa, (sb < -16) ? 16 : -sb);
        else r = q15_right(sa, sb);
      end
      sfpalu_pkg::OP_NORM_S: r = sign_bits(sa, 64'sh4000, 15);
      sfpalu_pkg::OP_NORM_L: r = sign_bits(la, 64'sh4000_0000, 31);
      sfpalu_pkg::OP_EXTRACT_L: begin
        half = w.long_a[15:0];
        r = half;
      end
      sfpalu_pkg::OP_EXTRACT_H: r = la >>> 16;
      sfpalu_pkg::OP_LMAX:      r = (la >= lb) ? la : lb;
      sfpalu_pkg::OP_LMIN:      r = (la <= lb) ? la : lb;
      sfpalu_pkg::OP_SMIN:      r = (sa <= sb) ? sa : sb;
      sfpalu_pkg::OP_SAND: begin
        half = w.short_a & w.short_b;
        r = half;
      end
      default:      r = 0;
    endcase
    o.func     = w.func;
    o.result   = r[31:0];
    o.overflow = q_sat;
    return o;
  endfunction

  function automatic logic [31:0] pick_long();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: return sfpalu_pkg::MAX32;
      1: return sfpalu_pkg::MIN32;
      2: return '0;
      3: return '1;
      4: return 32'(int'($urandom_range(64)) - 32);
      5: return v >>> $urandom_range(31);
      default: return v;
    endcase
  endfunction

  function automatic logic [15:0] pick_short();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(7))
      0: return sfpalu_pkg::MAX16;
      1: return sfpalu_pkg::MIN16;
      2: return '0;
      3: return '1;
      4: return 16'(int'($urandom_range(64)) - 32);
      5: return v >>> $urandom_range(15);
      default: return v;
    endcase
  endfunction

  task automatic queue_word(input logic [4:0] f, input logic [31:0] la, input logic [31:0] lb,
                            input logic [15:0] sa, input logic [15:0] sb);
    sfpalu_pkg::in_t w;
    w.func    = f;
    w.long_a  = la;
    w.long_b  = lb;
    w.short_a = sa;
    w.short_b = sb;
    pending_words.push_back(w);
  endtask

  // Driver: a new word is presented only once the previous one was taken.
  always @(posedge clk) begin : drive_words
    sfpalu_pkg::in_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        func     <= w.func;
        long_a   <= w.long_a;
        long_b   <= w.long_b;
        short_a  <= w.short_a;
        short_b  <= w.short_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin : score_words
    alu_outcome_t    e;
    sfpalu_pkg::in_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected word, expected none, actual result %h overflow %b",
                     $time, result, overflow);
        end else begin
          e = predicted_results.pop_front();
          if (result !== e.result) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: func %0d result expected %h actual %h",
                       $time, e.func, e.result, result);
          end
          if (overflow !== e.overflow) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: func %0d overflow expected %b actual %b",
                       $time, e.func, e.overflow, overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        w.func    = func;
        w.long_a  = long_a;
        w.long_b  = long_b;
        w.short_a = short_a;
        w.short_b = short_b;
        predicted_results.push_back(alu_predict(w));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          send_pct[4];
    int          stall_pct[4];
    logic [4:0]  f;
    logic [15:0] count;
    send_pct  = '{0, 77, 0, 10};
    stall_pct = '{0, 0, 77, 10};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words: every operation, field extremes and the corner cases.
    queue_word(sfpalu_pkg::OP_ADD, sfpalu_pkg::MAX32, 32'sd1, '0, '0);
    queue_word(sfpalu_pkg::OP_SUB, sfpalu_pkg::MIN32, 32'sd1, '0, '0);
    queue_word(sfpalu_pkg::OP_MULT, '0, '0, sfpalu_pkg::MIN16, sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_MULT0, '0, '0, sfpalu_pkg::MIN16, sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_MAC, sfpalu_pkg::MAX32, '0, 16'sd1000, 16'sd1000);
    queue_word(sfpalu_pkg::OP_MAC0, sfpalu_pkg::MIN32, '0, sfpalu_pkg::MIN16,
               sfpalu_pkg::MAX16);
    queue_word(sfpalu_pkg::OP_MSU0, 32'sh1234_5678, '0, sfpalu_pkg::MAX16,
               sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_MAC_R, 32'sh7fff_0000, '0, 16'sd2, 16'sd3);
    queue_word(sfpalu_pkg::OP_ROUND, sfpalu_pkg::MAX32, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_LSHL, 32'sd1, '0, '0, sfpalu_pkg::MAX16);
    queue_word(sfpalu_pkg::OP_LSHL, '0, '0, '0, 16'sd40);
    queue_word(sfpalu_pkg::OP_LSHL, sfpalu_pkg::MIN32, '0, '0, sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_LSHR, -32'sd5, '0, '0, sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_LSHR, sfpalu_pkg::MIN32, '0, '0, 16'sd31);
    queue_word(sfpalu_pkg::OP_SHL, '0, '0, sfpalu_pkg::MIN16, sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_SHL, '0, '0, 16'sd1, 16'sd20);
    queue_word(sfpalu_pkg::OP_SHR, '0, '0, 16'sh4000, 16'sd15);
    queue_word(sfpalu_pkg::OP_SHR, '0, '0, 16'sd3, -16'sd3);
    queue_word(sfpalu_pkg::OP_NORM_S, '0, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_NORM_S, '0, '0, '1, '0);
    queue_word(sfpalu_pkg::OP_NORM_L, '1, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_NORM_L, 32'sd1, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_EXTRACT_L, 32'sh1234_8000, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_EXTRACT_H, sfpalu_pkg::MIN32, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_LMAX, sfpalu_pkg::MIN32, sfpalu_pkg::MAX32, '0, '0);
    queue_word(sfpalu_pkg::OP_LMIN, '1, '0, '0, '0);
    queue_word(sfpalu_pkg::OP_SMIN, '0, '0, sfpalu_pkg::MAX16, sfpalu_pkg::MIN16);
    queue_word(sfpalu_pkg::OP_SAND, '0, '0, '1, sfpalu_pkg::MIN16);
    queue_word(OP_UNUSED_TOP, sfpalu_pkg::MAX32, sfpalu_pkg::MAX32, sfpalu_pkg::MAX16,
               sfpalu_pkg::MAX16);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = stall_pct[phase];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ($urandom_range(19) == 0)
          f = 5'($urandom_range(OP_UNUSED_TOP, sfpalu_pkg::OP_SAND + 1));
        else
          f = 5'($urandom_range(sfpalu_pkg::OP_SAND));
        // Shift counts mostly land near the interesting range around +-32.
        if ((f == sfpalu_pkg::OP_LSHL || f == sfpalu_pkg::OP_LSHR ||
             f == sfpalu_pkg::OP_SHL || f == sfpalu_pkg::OP_SHR) &&
            $urandom_range(3) != 0)
          count = 16'(int'($urandom_range(96)) - 48);
        else
          count = pick_short();
        queue_word(f, pick_long(), pick_long(), pick_short(), count);
      end
      while (pending_words.size() != 0 || in_valid) @(negedge clk);
    end

    while (predicted_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
